// File: src/kbgd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the k-bonacci greedy decomposer.
// No dependencies; imported by the table module and the top level.
package kbgd_pkg;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_ORDER_K = '0;

	// order register
	localparam int ORDER_W = 6;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd2;
	localparam logic [ORDER_W-1:0] ORDER_MIN = 6'd2;
	localparam logic [ORDER_W-1:0] ORDER_MAX = 6'd32;

	// results per target, filler included
	localparam int MAX_RESULTS = 33;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} walk_state_t;

endpackage

// File: src/kbonacci_greedy_decompose.sv
`timescale 1ns / 1ps
// Top level: configuration register, greedy walk over the term table, result register.
// Depends on kbgd_pkg and kbgd_table.
//
// Splits each target word into distinct k-bonacci terms, largest first, after a leading
// filler word of 0; the final word of a target has last_term set. The term table lives in
// one RAM and is refilled after reset and after every write of order_k, with in_ready low
// until the refill is done. A target is walked one table entry at a time, top entry down:
// one RAM read and one compare-subtract per entry, then a closing step that loads the last
// word; the walk ends early once the remainder is zero, and waits while the result register
// is full. One target is in work at a time; the next one is accepted while the last word
// still waits to be taken.
module kbonacci_greedy_decompose #(
	parameter int VALUE_WIDTH = 32,
	parameter int TABLE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kbgd_pkg::PADDR_W-1:0]     paddr,
	input  logic [kbgd_pkg::PDATA_W-1:0]     pwdata,
	output logic [kbgd_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	// targets
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [VALUE_WIDTH-1:0]           target_value,
	// terms
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [VALUE_WIDTH-1:0]           term,
	output logic                             last_term
);
	import kbgd_pkg::*;

	localparam int IDXW = $clog2(TABLE_DEPTH);
	localparam int EW   = VALUE_WIDTH + 1;

	logic [ORDER_W-1:0]     order_q;
	logic [ORDER_W-1:0]     order_eff;
	logic                   reg_sel, cfg_wr;

	walk_state_t            state_q, state_d;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] pend_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDXW-1:0]        chk_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] term_q;
	logic                   last_q;

	logic [IDXW-1:0]        walk_addr;
	logic [EW-1:0]          rd_data;
	logic                   built;

	logic                   accept, can_emit, qual, full, rem_zero, at_bottom;
	logic                   do_emit, emit_last, take_term, stall;

	// configuration port
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_ORDER_K);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_wr) begin
			order_q <= pwdata[ORDER_W-1:0];
		end
	end

	always_comb begin
		if (order_q < ORDER_MIN) begin
			order_eff = ORDER_MIN;
		end else if (order_q > ORDER_MAX) begin
			order_eff = ORDER_MAX;
		end else begin
			order_eff = order_q;
		end
	end

	kbgd_table #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rebuild   (cfg_wr),
		.order     (order_eff),
		.walk_addr (walk_addr),
		.rd_data   (rd_data),
		.built     (built)
	);

	// walk: rd_data holds entry chk_q during ST_WALK
	assign in_ready  = (state_q == ST_IDLE) && built;
	assign accept    = in_valid && in_ready;
	assign can_emit  = !out_valid_q || out_ready;
	assign qual      = (rd_data <= {1'b0, rem_q});
	assign full      = (cnt_q >= CNT_W'(MAX_RESULTS));
	assign rem_zero  = (rem_q == '0);
	assign at_bottom = (chk_q == IDXW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (rem_zero || (qual && full)) begin
					state_d = ST_FIN;
				end else if (!(qual && !can_emit) && at_bottom) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		do_emit   = 1'b0;
		emit_last = 1'b0;
		take_term = 1'b0;
		stall     = 1'b0;
		walk_addr = IDXW'(TABLE_DEPTH - 1);
		case (state_q)
			ST_IDLE: begin
				walk_addr = IDXW'(TABLE_DEPTH - 1);
			end
			ST_WALK: begin
				if (!rem_zero && qual && !full) begin
					if (can_emit) begin
						do_emit   = 1'b1;
						take_term = 1'b1;
					end else begin
						stall = 1'b1;
					end
				end
				// a stall re-reads the same entry
				walk_addr = stall ? chk_q : chk_q - IDXW'(1);
			end
			ST_FIN: begin
				do_emit   = can_emit;
				emit_last = 1'b1;
				walk_addr = chk_q;
			end
			default: begin
				walk_addr = chk_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			chk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CNT_W'(1);
				chk_q <= IDXW'(TABLE_DEPTH - 1);
			end else if (state_q == ST_WALK && !stall) begin
				chk_q <= chk_q - IDXW'(1);
				if (take_term) cnt_q <= cnt_q + CNT_W'(1);
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= target_value;
			pend_q <= '0;
		end else if (take_term) begin
			rem_q  <= rem_q - rd_data[VALUE_WIDTH-1:0];
			pend_q <= rd_data[VALUE_WIDTH-1:0];
		end
		if (do_emit) begin
			term_q <= pend_q;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign term      = term_q;
	assign last_term = last_q;

endmodule

// File: src/kbgd_table.sv
`timescale 1ns / 1ps
// Term table: one synchronous RAM plus the sequencer that fills it from the order.
// Depends on kbgd_pkg.
module kbgd_table #(
	parameter int VALUE_WIDTH = 32,
	parameter int TABLE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rebuild,
	input  logic [kbgd_pkg::ORDER_W-1:0]     order,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   walk_addr,
	output logic [VALUE_WIDTH:0]             rd_data,
	output logic                             built
);
	import kbgd_pkg::*;

	localparam int IDXW = $clog2(TABLE_DEPTH);
	localparam int EW   = VALUE_WIDTH + 1;
	localparam int CMPW = ((IDXW > ORDER_W) ? IDXW : ORDER_W) + 1;

	logic [EW-1:0]   mem [TABLE_DEPTH];
	logic [EW-1:0]   rd_q;
	logic [EW-1:0]   prev_q;
	logic [IDXW-1:0] b_q;
	logic            built_q;

	logic [CMPW-1:0] b_ext, k_ext, back_idx;
	logic            use_sub;
	logic [EW-1:0]   wdata;
	logic [IDXW-1:0] rd_addr;
	logic            we;

	// t[b] = 2*t[b-1] - t[b-1-k]; the older term was read in the previous cycle
	assign b_ext    = CMPW'(b_q);
	assign k_ext    = CMPW'(order);
	assign back_idx = b_ext - k_ext;
	assign use_sub  = (b_ext >= k_ext + CMPW'(2));

	always_comb begin
		if (b_q <= IDXW'(2)) begin
			wdata = EW'(1);
		end else if (prev_q[EW-1]) begin
			// already beyond any target: stays saturated
			wdata = '1;
		end else begin
			wdata = {prev_q[EW-2:0], 1'b0} - (use_sub ? rd_q : '0);
		end
	end

	assign we      = !built_q && !rebuild;
	assign rd_addr = built_q ? walk_addr : back_idx[IDXW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q     <= IDXW'(1);
			built_q <= 1'b0;
		end else if (rebuild) begin
			b_q     <= IDXW'(1);
			built_q <= 1'b0;
		end else if (!built_q) begin
			b_q <= b_q + IDXW'(1);
			if (b_q == IDXW'(TABLE_DEPTH - 1)) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[b_q] <= wdata;
			prev_q   <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
	assign built   = built_q;

endmodule

// File: src/kbgd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for kbonacci_greedy_decompose and the bind that attaches them.
// Depends on the top level's ports only.
module kbgd_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] term,
	input logic                   last_term
);

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(term) && $stable(last_term))
		else $error("result word changed while stalled");

	// one target at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting a word");

	// while a non-final word is shown the target is still in work
	a_busy_mid_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_term |-> !in_ready)
		else $error("input ready before the final word of a target");

	// right after acceptance only a previous final word can be pending
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || last_term)
		else $error("non-final word present right after acceptance");

endmodule

bind kbonacci_greedy_decompose kbgd_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_kbgd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.term      (term),
	.last_term (last_term)
);
